>>> hdl/rdpc_pkg.sv
`default_nettype none

package rdpc_pkg;

	localparam int NL      = 4;   // pad edges: x low, x high, y low, y high
	localparam int TIME_W  = 24;
	localparam int POS_W   = 21;
	localparam int OFF_W   = 22;
	localparam int MAG_W   = 22;
	localparam int RATE_W  = 32;
	localparam int CFG_W   = 32;
	localparam int PROD_W  = 56;
	localparam int VAR_W   = 59;
	localparam int SQ_N    = 29;  // root bits
	localparam int SIG_W   = 29;
	localparam int NUM_W   = 46;  // |offset| * 46341 * 256
	localparam int Q_W     = 18;  // erf argument, Q16 below 4.0
	localparam int REM_W   = 47;
	localparam int ERF_W   = 31;
	localparam int ACC_W   = 56;
	localparam int OUT_W   = 35;

	localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
	localparam longint unsigned TWO_OVER_SQRTPI_Q30 = 64'd1211587905;
	localparam logic [ERF_W-1:0] ERF_ONE = 31'h4000_0000;
	localparam logic signed [38:0] OUT_MAX = 39'sh3_FFFF_FFFF;
	localparam logic signed [38:0] OUT_MIN = -39'sh4_0000_0000;

	typedef enum logic [2:0] {
		CFG_DIFF_RATE,
		CFG_WIDTH_SQ,
		CFG_NORM,
		CFG_ION_MODE,
		CFG_ION_TIME,
		CFG_SLOW_RATE,
		CFG_FAST_RATE
	} cfg_idx_t;

	typedef struct packed {
		logic          pos;   // elapsed time above zero
		logic [NL-1:0] neg;   // offset below zero
		logic [NL-1:0] zro;   // offset is zero
	} lane_flags_t;

endpackage

`default_nettype wire

>>> hdl/resistive_diffusion_pad_charge_top.sv
// Resistive-layer pad charge pipeline.
// Input channel: in_valid/in_stall with sample_time, deposit_time, cloud center
// and the four pad edges. A request is taken at a clock edge where in_valid is
// high and in_stall is low.
// Output channel: out_valid/out_stall with pad_charge (1/256 electron, signed,
// saturated). One result per request, in request order.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while no request is in flight.
// Pipeline: 60 register stages; out_valid is the last stage's valid bit. One
// request per cycle unless the output stalls. Depth is set by the square root
// (a load stage, then 29 stages of one root bit each) and the 19-stage divider
// (a range check, then one quotient bit per stage, four lanes).
// Stall: the whole pipe freezes while the output register holds a result that
// the receiver stalls; in_stall is raised in that cycle. Bubbles are carried
// by a per-stage valid bit.
// Reset (arst_n low): pipe valid bits clear, registers take their defaults
// (ion_time 400 ns, slow/fast rate 2621440000, others 0).
// The erf table (ERF_SEGMENTS Hermite segments over [0,4]) is built at
// elaboration and read as a constant ROM.
`default_nettype none

module resistive_diffusion_pad_charge_top
	import rdpc_pkg::*;
#(
	parameter int ERF_SEGMENTS = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire        [TIME_W-1:0] sample_time,
	input  wire        [TIME_W-1:0] deposit_time,
	input  wire signed [POS_W-1:0]  x_center,
	input  wire signed [POS_W-1:0]  y_center,
	input  wire signed [POS_W-1:0]  x_low,
	input  wire signed [POS_W-1:0]  x_high,
	input  wire signed [POS_W-1:0]  y_low,
	input  wire signed [POS_W-1:0]  y_high,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic signed [OUT_W-1:0] pad_charge,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire        [2:0]        cfg_index,
	input  wire        [CFG_W-1:0]  cfg_data
);

	localparam int IW  = $clog2(ERF_SEGMENTS + 1);
	localparam int NST = 2 + (SQ_N + 1) + (Q_W + 1) + 6 + 3;

	// table build divisors
	localparam longint unsigned SEG_SQ   = 64'(ERF_SEGMENTS) * 64'(ERF_SEGMENTS);
	localparam longint unsigned SIMP_DEN = (64'd3 * 64'(ERF_SEGMENTS)) << 28;
	localparam longint unsigned SEG_DIV  = 64'(ERF_SEGMENTS);

	// ---------------- erf table, built at elaboration ----------------
	// Taylor term divide by the term index
	function automatic longint unsigned div_small(input longint unsigned v, input int n);
		longint unsigned q;
		case (n)
			1:       q = v;
			2:       q = v >> 1;
			3:       q = v / 3;
			4:       q = v >> 2;
			5:       q = v / 5;
			6:       q = v / 6;
			7:       q = v / 7;
			8:       q = v >> 3;
			9:       q = v / 9;
			10:      q = v / 10;
			11:      q = v / 11;
			12:      q = v / 12;
			default: q = v;
		endcase
		return q;
	endfunction

	// exp(-x^2) in Q31 at x = 4*j/(2*ERF_SEGMENTS)
	function automatic longint unsigned gauss_q31(input longint unsigned j);
		longint unsigned y;
		longint unsigned z;
		longint unsigned term;
		longint unsigned r;
		longint sum;
		y = ((64'd4 * j * j) << 31) / SEG_SQ;
		z = y >> 6;
		term = 64'd1 << 31;
		sum = longint'(term);
		for (int n = 1; n <= 12; n++) begin
			term = div_small((term * z) >> 31, n);
			if ((n & 1) != 0)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(64'd1 << 31))
			sum = longint'(64'd1 << 31);
		r = longint'(sum);
		for (int n = 0; n < 6; n++)
			r = (r * r + (64'd1 << 30)) >> 31;
		return r;
	endfunction

	function automatic logic [(ERF_SEGMENTS+1)*ERF_W-1:0] build_nodes();
		logic [(ERF_SEGMENTS+1)*ERF_W-1:0] tab;
		longint unsigned acc;
		longint unsigned s;
		tab = '0;
		acc = 0;
		for (int k = 0; k < ERF_SEGMENTS; k++) begin
			s = gauss_q31(64'(2 * k)) + 64'd4 * gauss_q31(64'(2 * k + 1))
				+ gauss_q31(64'(2 * k + 2));
			acc = acc + ((s >> 2) * TWO_OVER_SQRTPI_Q30) / SIMP_DEN;
			tab[(k+1)*ERF_W +: ERF_W] = (acc > 64'(ERF_ONE)) ? ERF_ONE : ERF_W'(acc);
		end
		return tab;
	endfunction

	function automatic logic [(ERF_SEGMENTS+1)*ERF_W-1:0] build_slopes();
		logic [(ERF_SEGMENTS+1)*ERF_W-1:0] tab;
		longint unsigned g;
		tab = '0;
		for (int k = 0; k <= ERF_SEGMENTS; k++) begin
			g = gauss_q31(64'(2 * k));
			tab[k*ERF_W +: ERF_W] =
				ERF_W'((((g * TWO_OVER_SQRTPI_Q30) >> 31) * 64'd4) / SEG_DIV);
		end
		return tab;
	endfunction

	localparam logic [(ERF_SEGMENTS+1)*ERF_W-1:0] NODE_TAB  = build_nodes();
	localparam logic [(ERF_SEGMENTS+1)*ERF_W-1:0] SLOPE_TAB = build_slopes();

	// ---------------- configuration ----------------
	logic [RATE_W-1:0] diff_rate_q;
	logic [TIME_W-1:0] width_sq_q;
	logic [TIME_W-1:0] norm_q;
	logic              ion_mode_q;
	logic [TIME_W-1:0] ion_time_q;
	logic [RATE_W-1:0] slow_rate_q;
	logic [RATE_W-1:0] fast_rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_rate_q <= '0;
			width_sq_q  <= '0;
			norm_q      <= '0;
			ion_mode_q  <= 1'b0;
			ion_time_q  <= 24'd400;
			slow_rate_q <= 32'd2621440000;
			fast_rate_q <= 32'd2621440000;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DIFF_RATE: diff_rate_q <= cfg_data;
				CFG_WIDTH_SQ:  width_sq_q  <= cfg_data[TIME_W-1:0];
				CFG_NORM:      norm_q      <= cfg_data[TIME_W-1:0];
				CFG_ION_MODE:  ion_mode_q  <= cfg_data[0];
				CFG_ION_TIME:  ion_time_q  <= cfg_data[TIME_W-1:0];
				CFG_SLOW_RATE: slow_rate_q <= cfg_data;
				CFG_FAST_RATE: fast_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// Global advance: the pipe moves unless the output register is held.
	logic             en;
	logic             in_acc;
	logic [NST-1:0]   vld_sk;

	assign en        = !(vld_sk[NST-1] && out_stall);
	assign in_stall  = !en;
	assign in_acc    = in_valid && en;
	assign out_valid = vld_sk[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk <= '0;
		end else if (en) begin
			vld_sk <= {vld_sk[NST-2:0], in_acc};
		end
	end

	// ---------------- s1: elapsed time, edge offsets ----------------
	logic [TIME_W:0]          dt_c;
	logic                     pos_s1;
	logic [TIME_W-1:0]        t_s1;
	logic signed [OFF_W-1:0]  off_s1 [NL];

	assign dt_c = {1'b0, sample_time} - {1'b0, deposit_time};

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1    <= !dt_c[TIME_W] && (dt_c != '0);
			t_s1      <= dt_c[TIME_W-1:0];
			off_s1[0] <= OFF_W'(x_low)  - OFF_W'(x_center);
			off_s1[1] <= OFF_W'(x_high) - OFF_W'(x_center);
			off_s1[2] <= OFF_W'(y_low)  - OFF_W'(y_center);
			off_s1[3] <= OFF_W'(y_high) - OFF_W'(y_center);
		end
	end

	// ---------------- s2: rate products, magnitudes ----------------
	logic [PROD_W-1:0] m1_s2, m2_s2, m3_s2;
	logic              ge_s2, ion_s2;
	logic [MAG_W-1:0]  mag_s2 [NL];
	lane_flags_t       fl_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2  <= t_s1 * (ion_mode_q ? slow_rate_q : diff_rate_q);
			m2_s2  <= (t_s1 - ion_time_q) * fast_rate_q;
			m3_s2  <= ion_time_q * slow_rate_q;
			ge_s2  <= t_s1 >= ion_time_q;
			ion_s2 <= ion_mode_q;
			fl_s2.pos <= pos_s1;
			for (int k = 0; k < NL; k++) begin
				mag_s2[k]     <= off_s1[k][OFF_W-1] ? MAG_W'(-off_s1[k]) : MAG_W'(off_s1[k]);
				fl_s2.neg[k]  <= off_s1[k][OFF_W-1];
				fl_s2.zro[k]  <= off_s1[k] == '0;
			end
		end
	end

	// ---------------- s3..s32: variance, then square root ----------------
	// Stage 0 of the root array holds the variance; each later stage resolves
	// one root bit.
	logic [VAR_W-1:0] sq_v_sk   [SQ_N+1];
	logic [VAR_W-1:0] sq_r_sk   [SQ_N+1];
	logic [NUM_W-1:0] sq_num_sk [SQ_N+1][NL];
	lane_flags_t      sq_fl_sk  [SQ_N+1];
	logic [PROD_W:0]  grow_c;

	assign grow_c = (ion_s2 && ge_s2) ? ((PROD_W+1)'(m2_s2) + (PROD_W+1)'(m3_s2))
	                                  : (PROD_W+1)'(m1_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_sk[0]  <= VAR_W'({width_sq_q, 16'b0}) + VAR_W'(grow_c);
			sq_r_sk[0]  <= '0;
			sq_fl_sk[0] <= fl_s2;
			for (int k = 0; k < NL; k++)
				sq_num_sk[0][k] <= {(NUM_W-8)'(mag_s2[k]) * (NUM_W-8)'(INV_SQRT2_Q16), 8'b0};
		end
	end

	for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
		localparam logic [VAR_W-1:0] BIT = VAR_W'(1) << (2 * (SQ_N - 1 - i));
		logic [VAR_W-1:0] trial;
		assign trial = sq_r_sk[i] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (sq_v_sk[i] >= trial) begin
					sq_v_sk[i+1] <= sq_v_sk[i] - trial;
					sq_r_sk[i+1] <= (sq_r_sk[i] >> 1) + BIT;
				end else begin
					sq_v_sk[i+1] <= sq_v_sk[i];
					sq_r_sk[i+1] <= sq_r_sk[i] >> 1;
				end
				sq_fl_sk[i+1] <= sq_fl_sk[i];
				sq_num_sk[i+1] <= sq_num_sk[i];
			end
		end
	end

	// ---------------- s33..s51: offset / sigma, four lanes ----------------
	// First stage flags quotients of 4.0 or more (erf saturates; also covers
	// sigma of zero). The rest restore one quotient bit each.
	logic [SIG_W-1:0] dv_sig_sk [Q_W+1];
	logic [REM_W-1:0] dv_rem_sk [Q_W+1][NL];
	logic [Q_W-1:0]   dv_q_sk   [Q_W+1][NL];
	logic [NL-1:0]    dv_sat_sk [Q_W+1];
	lane_flags_t      dv_fl_sk  [Q_W+1];
	logic [SIG_W-1:0] sig_c;

	assign sig_c = sq_r_sk[SQ_N][SIG_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_sig_sk[0] <= sig_c;
			dv_fl_sk[0]  <= sq_fl_sk[SQ_N];
			for (int k = 0; k < NL; k++) begin
				dv_rem_sk[0][k] <= REM_W'(sq_num_sk[SQ_N][k]);
				dv_q_sk[0][k]   <= '0;
				dv_sat_sk[0][k] <= REM_W'(sq_num_sk[SQ_N][k]) >= (REM_W'(sig_c) << Q_W);
			end
		end
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int QB = Q_W - 1 - j;
		logic [REM_W-1:0] dvs;
		assign dvs = REM_W'(dv_sig_sk[j]) << QB;
		always_ff @(posedge clk) begin
			if (en) begin
				dv_sig_sk[j+1] <= dv_sig_sk[j];
				dv_fl_sk[j+1]  <= dv_fl_sk[j];
				dv_sat_sk[j+1] <= dv_sat_sk[j];
				for (int k = 0; k < NL; k++) begin
					if (dv_rem_sk[j][k] >= dvs) begin
						dv_rem_sk[j+1][k] <= dv_rem_sk[j][k] - dvs;
						dv_q_sk[j+1][k]   <= dv_q_sk[j][k] | (Q_W'(1) << QB);
					end else begin
						dv_rem_sk[j+1][k] <= dv_rem_sk[j][k];
						dv_q_sk[j+1][k]   <= dv_q_sk[j][k];
					end
				end
			end
		end
	end

	// ---------------- s52: segment and fraction ----------------
	logic [Q_W+IW-1:0] up_c   [NL];
	logic [IW-1:0]     seg_s52 [NL];
	logic [15:0]       f_s52   [NL];
	logic [NL-1:0]     sat_s52;
	lane_flags_t       fl_s52;

	always_comb begin
		for (int k = 0; k < NL; k++)
			up_c[k] = (Q_W+IW)'(dv_q_sk[Q_W][k]) * (Q_W+IW)'(ERF_SEGMENTS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s52 <= dv_sat_sk[Q_W];
			fl_s52  <= dv_fl_sk[Q_W];
			for (int k = 0; k < NL; k++) begin
				if (up_c[k][Q_W+IW-1:Q_W] >= IW'(ERF_SEGMENTS))
					seg_s52[k] <= IW'(ERF_SEGMENTS - 1);
				else
					seg_s52[k] <= up_c[k][Q_W+IW-1:Q_W];
				f_s52[k] <= up_c[k][Q_W-1:2];
			end
		end
	end

	// ---------------- s53: table read, f^2 ----------------
	logic [ERF_W-1:0] n0_s53 [NL];
	logic [ERF_W-1:0] n1_s53 [NL];
	logic [ERF_W-1:0] a_s53  [NL];
	logic [ERF_W-1:0] b_s53  [NL];
	logic [15:0]      f_s53  [NL];
	logic [15:0]      f2_s53 [NL];
	logic [31:0]      ff_c   [NL];
	logic [NL-1:0]    sat_s53;
	lane_flags_t      fl_s53;

	always_comb begin
		for (int k = 0; k < NL; k++)
			ff_c[k] = f_s52[k] * f_s52[k];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s53 <= sat_s52;
			fl_s53  <= fl_s52;
			for (int k = 0; k < NL; k++) begin
				n0_s53[k] <= NODE_TAB[int'(seg_s52[k]) * ERF_W +: ERF_W];
				n1_s53[k] <= NODE_TAB[(int'(seg_s52[k]) + 1) * ERF_W +: ERF_W];
				a_s53[k]  <= SLOPE_TAB[int'(seg_s52[k]) * ERF_W +: ERF_W];
				b_s53[k]  <= SLOPE_TAB[(int'(seg_s52[k]) + 1) * ERF_W +: ERF_W];
				f_s53[k]  <= f_s52[k];
				f2_s53[k] <= ff_c[k][31:16];
			end
		end
	end

	// ---------------- s54: Hermite coefficients, f^3 ----------------
	logic signed [35:0] c2_s54 [NL];
	logic signed [35:0] c3_s54 [NL];
	logic [ERF_W-1:0]   n0_s54 [NL];
	logic [ERF_W-1:0]   a_s54  [NL];
	logic [15:0]        f_s54  [NL];
	logic [15:0]        f2_s54 [NL];
	logic [15:0]        f3_s54 [NL];
	logic [31:0]        fff_c  [NL];
	logic signed [35:0] d_c    [NL];
	logic signed [35:0] as_c   [NL];
	logic signed [35:0] bs_c   [NL];
	logic [NL-1:0]      sat_s54;
	lane_flags_t        fl_s54;

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			fff_c[k] = f2_s53[k] * f_s53[k];
			d_c[k]   = $signed(36'(n1_s53[k])) - $signed(36'(n0_s53[k]));
			as_c[k]  = $signed(36'(a_s53[k]));
			bs_c[k]  = $signed(36'(b_s53[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s54 <= sat_s53;
			fl_s54  <= fl_s53;
			for (int k = 0; k < NL; k++) begin
				c2_s54[k] <= 36'sd3 * d_c[k] - 36'sd2 * as_c[k] - bs_c[k];
				c3_s54[k] <= as_c[k] + bs_c[k] - 36'sd2 * d_c[k];
				n0_s54[k] <= n0_s53[k];
				a_s54[k]  <= a_s53[k];
				f_s54[k]  <= f_s53[k];
				f2_s54[k] <= f2_s53[k];
				f3_s54[k] <= fff_c[k][31:16];
			end
		end
	end

	// ---------------- s55: polynomial terms ----------------
	logic signed [ACC_W-1:0] pa_s55 [NL];
	logic signed [ACC_W-1:0] p2_s55 [NL];
	logic signed [ACC_W-1:0] p3_s55 [NL];
	logic [ERF_W-1:0]        n0_s55 [NL];
	logic [NL-1:0]           sat_s55;
	lane_flags_t             fl_s55;

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s55 <= sat_s54;
			fl_s55  <= fl_s54;
			for (int k = 0; k < NL; k++) begin
				pa_s55[k] <= $signed({1'b0, a_s54[k]}) * $signed({1'b0, f_s54[k]});
				p2_s55[k] <= c2_s54[k] * $signed({1'b0, f2_s54[k]});
				p3_s55[k] <= c3_s54[k] * $signed({1'b0, f3_s54[k]});
				n0_s55[k] <= n0_s54[k];
			end
		end
	end

	// ---------------- s56: erf per edge ----------------
	logic signed [ACC_W-1:0] acc_c [NL];
	logic signed [ACC_W-1:0] ev_c  [NL];
	logic [ERF_W-1:0]        em_c  [NL];
	logic signed [31:0]      e_s56 [NL];
	logic                    pos_s56;

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			acc_c[k] = pa_s55[k] + p2_s55[k] + p3_s55[k];
			ev_c[k]  = $signed(ACC_W'(n0_s55[k])) + (acc_c[k] >>> 16);
			if (fl_s55.zro[k])
				em_c[k] = '0;
			else if (sat_s55[k] || ev_c[k] > $signed(ACC_W'(ERF_ONE)))
				em_c[k] = ERF_ONE;
			else if (ev_c[k] < 0)
				em_c[k] = '0;
			else
				em_c[k] = ev_c[k][ERF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s56 <= fl_s55.pos;
			for (int k = 0; k < NL; k++)
				e_s56[k] <= fl_s55.neg[k] ? -$signed(32'(em_c[k])) : $signed(32'(em_c[k]));
		end
	end

	// ---------------- s57..s60: differences, products, saturation ----------------
	logic signed [32:0] dx_s57, dy_s57;
	logic signed [65:0] pxy_s58;
	logic signed [60:0] m_s59;
	logic               pos_s57, pos_s58, pos_s59;
	logic signed [OUT_W-1:0] charge_q;
	logic signed [38:0] qv_c;

	assign qv_c = m_s59[60:22];

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s57  <= 33'(e_s56[1]) - 33'(e_s56[0]);
			dy_s57  <= 33'(e_s56[3]) - 33'(e_s56[2]);
			pos_s57 <= pos_s56;
			pxy_s58 <= dx_s57 * dy_s57;
			pos_s58 <= pos_s57;
			// floor(dx*dy / 2^30) then times norm
			m_s59   <= $signed(pxy_s58[65:30]) * $signed({1'b0, norm_q});
			pos_s59 <= pos_s58;
			if (!pos_s59)
				charge_q <= '0;
			else if (qv_c > OUT_MAX)
				charge_q <= OUT_MAX[OUT_W-1:0];
			else if (qv_c < OUT_MIN)
				charge_q <= OUT_MIN[OUT_W-1:0];
			else
				charge_q <= qv_c[OUT_W-1:0];
		end
	end

	assign pad_charge = charge_q;

endmodule

`default_nettype wire

>>> tb/pad_charge_checker.sv
`default_nettype none

module pad_charge_checker
	import rdpc_pkg::*;
#(
	parameter int ERF_SEGMENTS = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  wire                     in_stall,
	input  wire        [TIME_W-1:0] sample_time,
	input  wire        [TIME_W-1:0] deposit_time,
	input  wire signed [POS_W-1:0]  x_center,
	input  wire signed [POS_W-1:0]  y_center,
	input  wire signed [POS_W-1:0]  x_low,
	input  wire signed [POS_W-1:0]  x_high,
	input  wire signed [POS_W-1:0]  y_low,
	input  wire signed [POS_W-1:0]  y_high,
	input  wire                     out_valid,
	input  wire                     out_stall,
	input  wire signed [OUT_W-1:0]  pad_charge,
	input  wire                     cfg_valid,
	input  wire                     cfg_ready,
	input  wire        [2:0]        cfg_index,
	input  wire        [CFG_W-1:0]  cfg_data,
	output int                      errors,
	output int                      checked,
	output int                      pending
);

	localparam longint ONE_Q30 = 64'sd1 << 30;

	// shadow registers
	logic [31:0] diff_rate, slow_r, fast_r;
	logic [23:0] w_sq, norm, t_ion;
	logic        ion_on;

	longint unsigned erf_val[0:ERF_SEGMENTS];
	longint unsigned erf_der[0:ERF_SEGMENTS];

	logic signed [OUT_W-1:0] charge_due[$];

	// exp(-x^2), Q31, on a half-segment grid
	function automatic longint unsigned gauss_q31(longint unsigned j);
		longint unsigned n2, y, z, term, r;
		longint sum;
		n2 = ERF_SEGMENTS * ERF_SEGMENTS;
		y = ((64'd4 * j * j) << 31) / n2;
		z = y >> 6;
		term = 64'd1 << 31;
		sum = term;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * z) >> 31) / n;
			if (n % 2) sum -= term;
			else sum += term;
		end
		if (sum < 0) sum = 0;
		if (sum > (64'sd1 << 31)) sum = 64'sd1 << 31;
		r = sum;
		for (int n = 0; n < 6; n++)
			r = (r * r + (64'd1 << 30)) >> 31;
		return r;
	endfunction

	function automatic longint unsigned seg_slope(longint unsigned g);
		return (((g * TWO_OVER_SQRTPI_Q30) >> 31) * 64'd4) / ERF_SEGMENTS;
	endfunction

	initial begin
		longint unsigned run, s, g0, gm, g1;
		run = 0;
		erf_val[0] = 0;
		for (int k = 0; k < ERF_SEGMENTS; k++) begin
			g0 = gauss_q31(2 * k);
			gm = gauss_q31(2 * k + 1);
			g1 = gauss_q31(2 * k + 2);
			s = g0 + 4 * gm + g1;
			run += ((s >> 2) * TWO_OVER_SQRTPI_Q30) / ((64'd3 * ERF_SEGMENTS) << 28);
			erf_val[k + 1] = run > ONE_Q30 ? ONE_Q30 : run;
			erf_der[k] = seg_slope(g0);
		end
		erf_der[ERF_SEGMENTS] = seg_slope(gauss_q31(2 * ERF_SEGMENTS));
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// erf(off / (sqrt2 * sigma)), Q30; sigma is Q8.8
	function automatic longint edge_erf(longint off, longint unsigned sigma);
		longint unsigned mag, u, pos, seg;
		longint f, f2, f3, e0, d, a, b, c2, c3, acc, e;
		if (off == 0) return 0;
		mag = off < 0 ? -off : off;
		if (sigma == 0) begin
			e = ONE_Q30;
		end else begin
			u = ((mag * INV_SQRT2_Q16) << 8) / sigma;
			if (u >= (64'd4 << 16)) begin
				e = ONE_Q30;
			end else begin
				pos = (u * ERF_SEGMENTS) >> 2;
				seg = pos >> 16;
				f = longint'(pos & 64'hFFFF);
				if (seg >= ERF_SEGMENTS) seg = ERF_SEGMENTS - 1;
				e0 = longint'(erf_val[seg]);
				d = longint'(erf_val[seg + 1]) - e0;
				a = longint'(erf_der[seg]);
				b = longint'(erf_der[seg + 1]);
				c2 = 3 * d - 2 * a - b;
				c3 = a + b - 2 * d;
				f2 = (f * f) >>> 16;
				f3 = (f2 * f) >>> 16;
				acc = a * f + c2 * f2 + c3 * f3;
				e = e0 + (acc >>> 16);
				if (e < 0) e = 0;
				if (e > ONE_Q30) e = ONE_Q30;
			end
		end
		return off < 0 ? -e : e;
	endfunction

	function automatic logic signed [OUT_W-1:0] pad_charge_of(
		logic [TIME_W-1:0] ts, logic [TIME_W-1:0] td,
		logic signed [POS_W-1:0] xc, logic signed [POS_W-1:0] yc,
		logic signed [POS_W-1:0] xl, logic signed [POS_W-1:0] xh,
		logic signed [POS_W-1:0] yl, logic signed [POS_W-1:0] yh);
		longint dt, ex, ey, prod, q;
		longint unsigned t, spread, sigma;
		dt = longint'(ts) - longint'(td);
		if (dt <= 0) return '0;
		t = dt;
		spread = longint'(w_sq) << 16;
		if (ion_on) begin
			if (t < t_ion) spread += t * slow_r;
			else spread += (t - t_ion) * fast_r + longint'(t_ion) * slow_r;
		end else begin
			spread += t * diff_rate;
		end
		sigma = int_sqrt(spread);
		ex = edge_erf(longint'(xh) - longint'(xc), sigma)
			- edge_erf(longint'(xl) - longint'(xc), sigma);
		ey = edge_erf(longint'(yh) - longint'(yc), sigma)
			- edge_erf(longint'(yl) - longint'(yc), sigma);
		prod = (ex * ey) >>> 30;
		q = (prod * longint'(norm)) >>> 22;
		if (q > 64'sd17179869183) q = 64'sd17179869183;
		if (q < -64'sd17179869184) q = -64'sd17179869184;
		return q[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [OUT_W-1:0] want;
		if (!arst_n) begin
			diff_rate <= '0;
			w_sq <= '0;
			norm <= '0;
			ion_on <= 1'b0;
			t_ion <= 24'd400;
			slow_r <= 32'd2621440000;
			fast_r <= 32'd2621440000;
			charge_due.delete();
			errors = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_DIFF_RATE: diff_rate <= cfg_data;
					CFG_WIDTH_SQ:  w_sq <= cfg_data[23:0];
					CFG_NORM:      norm <= cfg_data[23:0];
					CFG_ION_MODE:  ion_on <= cfg_data[0];
					CFG_ION_TIME:  t_ion <= cfg_data[23:0];
					CFG_SLOW_RATE: slow_r <= cfg_data;
					CFG_FAST_RATE: fast_r <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				charge_due.push_back(pad_charge_of(sample_time, deposit_time, x_center,
					y_center, x_low, x_high, y_low, y_high));
			if (out_valid && !out_stall) begin
				if (charge_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected pad_charge %0d", $time, pad_charge);
				end else begin
					want = charge_due.pop_front();
					checked++;
					if (pad_charge !== want) begin
						errors++;
						$display("%0t: pad_charge expected %0d actual %0d", $time, want,
							pad_charge);
					end
				end
			end
			pending = charge_due.size();
		end
	end

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

module tb;
	import rdpc_pkg::*;

	localparam int ERF_SEG = 64;
	localparam int HANG_LIMIT = 3000;   // cycles without any handshake
	localparam int DRAIN_WAIT = 70;     // extra idle wait once no charge is pending
	localparam int PER_SET = 275;
	localparam logic [2:0] CFG_NO_REG = 3'd7;  // index past the register list

	typedef struct {
		logic [TIME_W-1:0] ts, td;
		logic signed [POS_W-1:0] xc, yc, xl, xh, yl, yh;
	} pad_req_t;

	typedef struct {
		logic [31:0] rate, slow, fast;
		logic [23:0] wsq, nrm, tion;
		logic        ion;
	} pad_cfg_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic [TIME_W-1:0] sample_time, deposit_time;
	logic signed [POS_W-1:0] x_center, y_center, x_low, x_high, y_low, y_high;
	logic signed [OUT_W-1:0] pad_charge;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int errors, checked, pending;
	int sender_idle_pct, stall_pct;
	int sent, hang_cycles;
	logic [23:0] cur_ion_time;

	resistive_diffusion_pad_charge_top #(.ERF_SEGMENTS(ERF_SEG)) uut (.*);

	pad_charge_checker #(.ERF_SEGMENTS(ERF_SEG)) scoreboard (
		.clk, .arst_n, .in_valid, .in_stall, .sample_time, .deposit_time,
		.x_center, .y_center, .x_low, .x_high, .y_low, .y_high,
		.out_valid, .out_stall, .pad_charge, .cfg_valid, .cfg_ready,
		.cfg_index, .cfg_data, .errors, .checked, .pending
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: random back-pressure, re-rolled every cycle
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// hang detector: any accepted request, result or register write resets it
	always @(posedge clk) begin
		if (!arst_n) begin
			hang_cycles <= 0;
		end else begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
				hang_cycles <= 0;
			end else if (hang_cycles >= HANG_LIMIT) begin
				$display("No handshake for %0d cycles after %0d requests; run stopped.",
					HANG_LIMIT, sent);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				hang_cycles <= hang_cycles + 1;
			end
		end
	end

	function automatic pad_req_t mk(int ts, int td, int xc, int yc,
		int xl, int xh, int yl, int yh);
		pad_req_t r;
		r.ts = TIME_W'(ts); r.td = TIME_W'(td);
		r.xc = POS_W'(xc); r.yc = POS_W'(yc);
		r.xl = POS_W'(xl); r.xh = POS_W'(xh); r.yl = POS_W'(yl); r.yh = POS_W'(yh);
		return r;
	endfunction

	// Mostly clouds near the pad with short drift times; some requests with
	// non-positive drift time and some with fully random fields.
	function automatic pad_req_t rand_req();
		pad_req_t r;
		int dtk, dep, xc, yc, xl, yl;
		int kind;
		kind = $urandom_range(99);
		if (kind < 20) begin
			r.ts = TIME_W'($urandom); r.td = TIME_W'($urandom);
			r.xc = POS_W'($urandom); r.yc = POS_W'($urandom);
			r.xl = POS_W'($urandom); r.xh = POS_W'($urandom);
			r.yl = POS_W'($urandom); r.yh = POS_W'($urandom);
			return r;
		end
		dtk = $urandom_range(1, 300);
		if ($urandom_range(9) == 0 && cur_ion_time != 0) dtk = cur_ion_time;
		dep = $urandom_range(0, 32'hFFFFFF - dtk);
		xc = int'($urandom_range(0, 4000)) - 2000;
		yc = int'($urandom_range(0, 4000)) - 2000;
		xl = xc + int'($urandom_range(0, 800)) - 500;
		yl = yc + int'($urandom_range(0, 800)) - 500;
		r = mk(dep + dtk, dep, xc, yc, xl, xl + int'($urandom_range(0, 700)) - 100,
			yl, yl + int'($urandom_range(0, 700)) - 100);
		if (kind < 30) begin
			// drift time zero or negative
			r.td = TIME_W'($urandom_range(1, 32'hFFFFFF));
			r.ts = TIME_W'($urandom_range(0, r.td));
		end
		if ($urandom_range(9) == 0) r.xl = r.xc;    // edge right on the center
		if ($urandom_range(9) == 0) r.yh = r.yc;
		return r;
	endfunction

	task automatic send_req(pad_req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_time <= r.ts; deposit_time <= r.td;
		x_center <= r.xc; y_center <= r.yc;
		x_low <= r.xl; x_high <= r.xh; y_low <= r.yl; y_high <= r.yh;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// wait for every outstanding charge, then let the pipe empty
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic load_cfg(pad_cfg_t c);
		write_reg(CFG_DIFF_RATE, c.rate);
		write_reg(CFG_WIDTH_SQ, {8'($urandom_range(255)), c.wsq});
		write_reg(CFG_NORM, {8'h00, c.nrm});
		write_reg(CFG_ION_MODE, {31'($urandom), c.ion});   // only bit 0 counts
		write_reg(CFG_ION_TIME, {8'hA5, c.tion});
		write_reg(CFG_SLOW_RATE, c.slow);
		write_reg(CFG_FAST_RATE, c.fast);
		write_reg(CFG_NO_REG, $urandom);               // must be ignored
		cfg_valid <= 1'b0;
		cur_ion_time = c.tion;
	endtask

	pad_cfg_t cfgs[7];

	initial begin
		in_valid = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		sample_time = '0; deposit_time = '0;
		x_center = '0; y_center = '0; x_low = '0; x_high = '0; y_low = '0; y_high = '0;
		sent = 0;
		sender_idle_pct = 25; stall_pct = 60;
		cur_ion_time = 24'd400;

		// sigma near 100 um for short drifts, full-scale norm
		cfgs[0] = '{rate: 32'(100 << 16), slow: 32'd2621440000, fast: 32'd2621440000,
			wsq: 24'd50, nrm: 24'hFFFFFF, tion: 24'd400, ion: 1'b0};
		// ion growth: slow up to 50 ns, fast after
		cfgs[1] = '{rate: 32'd0, slow: 32'(10 << 16), fast: 32'(200 << 16),
			wsq: 24'd0, nrm: 24'd1000, tion: 24'd50, ion: 1'b1};
		// every register at its top value, fast slope zero
		cfgs[2] = '{rate: 32'hFFFFFFFF, slow: 32'hFFFFFFFF, fast: 32'd0,
			wsq: 24'hFFFFFF, nrm: 24'hFFFFFF, tion: 24'hFFFFFF, ion: 1'b1};
		// no spread at all: sigma is zero, erf is the offset sign
		cfgs[3] = '{rate: 32'd0, slow: 32'd0, fast: 32'hFFFFFFFF,
			wsq: 24'd0, nrm: 24'd12345, tion: 24'd0, ion: 1'b0};
		// ion mode with ion time zero: always on the fast slope
		cfgs[4] = '{rate: 32'd0, slow: 32'd0, fast: 32'(50 << 16),
			wsq: 24'd3, nrm: 24'd777, tion: 24'd0, ion: 1'b1};
		// very narrow cloud
		cfgs[5] = '{rate: 32'd1, slow: 32'd1, fast: 32'd1,
			wsq: 24'd1, nrm: 24'h800000, tion: 24'd1, ion: 1'b0};
		// zero norm: charge always zero
		cfgs[6] = '{rate: 32'(40 << 16), slow: 32'(5 << 16), fast: 32'(7 << 16),
			wsq: 24'd1000, nrm: 24'd0, tion: 24'd100, ion: 1'b0};

		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int s = 0; s < 7; s++) begin
			// idling schedule: sender light / receiver heavy, then swapped, then none
			if (s < 3) begin sender_idle_pct = 25; stall_pct = 60; end
			else if (s < 5) begin sender_idle_pct = 60; stall_pct = 25; end
			else begin sender_idle_pct = 0; stall_pct = 0; end
			drain();
			load_cfg(cfgs[s]);
			if (s == 0) begin
				send_req(mk(1000, 1000, 0, 0, -50, 50, -50, 50));        // zero drift
				send_req(mk(0, 24'hFFFFFF, 0, 0, -50, 50, -50, 50));     // most negative
				send_req(mk(24'hFFFFFF, 0, 0, 0, -100, 100, -100, 100)); // longest drift
				send_req(mk(101, 1, 0, 0, -100, 100, -100, 100));
				send_req(mk(101, 1, 20, -30, 20, 20, -30, -30));         // zero-width pad
				send_req(mk(101, 1, 10, 10, 10, 200, 10, 200));          // edges on center
				send_req(mk(101, 1, 0, 0, 100, -100, -50, 50));          // x reversed
				send_req(mk(101, 1, 0, 0, 100, -100, 50, -50));          // both reversed
				send_req(mk(101, 1, 0, 0, -1048576, 1048575, -1048576, 1048575));
				send_req(mk(101, 1, -1048576, -1048576, 1048575, 1048575, 1048575,
					1048575));
				send_req(mk(101, 1, 1048575, 1048575, -1048576, -1048576, -1048576,
					1048575));
				send_req(mk(101, 1, 0, 0, 2000, 3000, -50, 50));         // far beyond 4 sigma
				send_req(mk(2, 1, 0, 0, -1, 1, -1, 1));                  // one ns drift
				send_req(mk(101, 1, -5, 7, -6, -4, 6, 8));               // pad inside a pixel
				send_req(mk(24'hFFFFFF, 24'hFFFFFE, 3, -3, -3, 9, 3, -9));
			end
			for (int n = 0; n < PER_SET; n++) send_req(rand_req());
		end

		drain();
		$display("Ran %0d pad requests through %0d register settings;", sent, 7);
		$display("%0d charges compared, %0d mismatches.", checked, errors);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
